// ----- rtl/usbhid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package usbhid_pkg;

  localparam int PKT_BYTES_DEF = 64;

  // item modes
  localparam logic [2:0] MODE_SETUP   = 3'd0;
  localparam logic [2:0] MODE_IN0     = 3'd1;
  localparam logic [2:0] MODE_OUT0    = 3'd2;
  localparam logic [2:0] MODE_OUT1    = 3'd3;
  localparam logic [2:0] MODE_IN1     = 3'd4;
  localparam logic [2:0] MODE_BUS_RST = 3'd5;
  localparam logic [2:0] MODE_REPLY   = 3'd6;

  // endpoint 0 handshakes
  localparam logic [1:0] HS_ACK   = 2'd0;
  localparam logic [1:0] HS_NAK   = 2'd1;
  localparam logic [1:0] HS_STALL = 2'd2;
  localparam logic [1:0] HS_KEEP  = 2'd3;

  // bmRequestType type field, bits 6:5
  localparam logic [1:0] RT_STANDARD = 2'd0;
  localparam logic [1:0] RT_CLASS    = 2'd1;
  // bmRequestType recipient field
  localparam logic [4:0] RCPT_ENDPOINT = 5'd2;

  // standard requests
  localparam logic [7:0] REQ_GET_STATUS    = 8'h00;
  localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
  localparam logic [7:0] REQ_SET_ADDRESS   = 8'h05;
  localparam logic [7:0] REQ_GET_DESC      = 8'h06;
  localparam logic [7:0] REQ_GET_CONFIG    = 8'h08;
  localparam logic [7:0] REQ_SET_CONFIG    = 8'h09;
  localparam logic [7:0] REQ_GET_IFACE     = 8'h0A;
  localparam logic [7:0] REQ_SET_IFACE     = 8'h0B;
  // hid class requests
  localparam logic [7:0] CLS_GET_REPORT    = 8'h01;
  localparam logic [7:0] CLS_GET_IDLE      = 8'h02;
  localparam logic [7:0] CLS_GET_PROTOCOL  = 8'h03;
  localparam logic [7:0] CLS_SET_REPORT    = 8'h09;
  localparam logic [7:0] CLS_SET_IDLE      = 8'h0A;
  localparam logic [7:0] CLS_SET_PROTOCOL  = 8'h0B;
  localparam logic [7:0] REQ_INVALID       = 8'hFF;

  // descriptor types
  localparam logic [7:0] DT_DEVICE = 8'h01;
  localparam logic [7:0] DT_CONFIG = 8'h02;
  localparam logic [7:0] DT_STRING = 8'h03;
  localparam logic [7:0] DT_HID    = 8'h21;
  localparam logic [7:0] DT_REPORT = 8'h22;

  localparam logic [7:0] EP1_IN_ADDR  = 8'h81;
  localparam logic [7:0] EP1_OUT_ADDR = 8'h01;

  // configuration register indexes
  localparam logic [1:0] CFG_VENDOR  = 2'd0;
  localparam logic [1:0] CFG_PRODUCT = 2'd1;
  localparam logic [1:0] CFG_CHIP_ID = 2'd2;

  // byte source while emitting
  localparam logic [1:0] SRC_ROM   = 2'd0;
  localparam logic [1:0] SRC_REPLY = 2'd1;
  localparam logic [1:0] SRC_FIXED = 2'd2;

  localparam logic [7:0] SERIAL_AT = 8'd130;
  localparam logic [7:0] IMAGE_LEN = 8'd152;

  typedef struct packed {
    logic latch;
    logic exec;
    logic fetch;
    logic send;
  } usbhid_cmd_t;

  typedef struct packed {
    logic last;
  } usbhid_status_t;

  localparam logic [7:0] ROM_IMAGE [0:129] = '{
    8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'h00, 8'h01, 8'd1, 8'd2, 8'd3, 8'd1,
    8'd9, 8'd2, 8'd41, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd50,
    8'd9, 8'd4, 8'd0, 8'd0, 8'd2, 8'h03, 8'h00, 8'h00, 8'd0,
    8'd9, 8'h21, 8'h11, 8'h01, 8'h00, 8'd1, 8'h22, 8'd27, 8'd0,
    8'd7, 8'd5, 8'h81, 8'h03, 8'd64, 8'd0, 8'd1,
    8'd7, 8'd5, 8'h01, 8'h03, 8'd64, 8'd0, 8'd1,
    8'h06, 8'h00, 8'hFF, 8'h09, 8'h01, 8'hA1, 8'h01, 8'h15, 8'h00, 8'h26, 8'hFF, 8'h00,
    8'h75, 8'h08, 8'h95, 8'h40, 8'h09, 8'h01, 8'h81, 8'h02, 8'h95, 8'h40,
    8'h09, 8'h01, 8'h91, 8'h02, 8'hC0,
    8'd4, 8'd3, 8'h09, 8'h04,
    8'd22, 8'd3, 8'h76, 8'd0, 8'h69, 8'd0, 8'h61, 8'd0, 8'h67, 8'd0, 8'h72, 8'd0,
    8'h69, 8'd0, 8'h64, 8'd0, 8'h5F, 8'd0, 8'h66, 8'd0, 8'h70, 8'd0,
    8'd18, 8'd3, 8'h59, 8'd0, 8'h4B, 8'd0, 8'h55, 8'd0, 8'h53, 8'd0, 8'h48, 8'd0,
    8'h2D, 8'd0, 8'h56, 8'd0, 8'h47, 8'd0
  };

  // one byte of the descriptor image, serial string computed from the chip id
  function automatic logic [7:0] image_byte(input logic [7:0] p, input logic [15:0] vid,
                                            input logic [15:0] pid, input logic [31:0] chip,
                                            input logic [7:0] pkt);
    logic [7:0] q;
    logic [2:0] d;
    logic [3:0] nib;
    logic [7:0] r;
    q = p - SERIAL_AT;
    d = 3'((q - 8'd6) >> 1);
    nib = 4'(chip >> (5'd28 - {d, 2'b00}));
    if (p == 8'd7) r = pkt;
    else if (p == 8'd8) r = vid[7:0];
    else if (p == 8'd9) r = vid[15:8];
    else if (p == 8'd10) r = pid[7:0];
    else if (p == 8'd11) r = pid[15:8];
    else if (p < SERIAL_AT) r = ROM_IMAGE[p];
    else if (p >= IMAGE_LEN) r = 8'd0;
    else if (q == 8'd0) r = 8'd22;
    else if (q == 8'd1) r = 8'd3;
    else if (q == 8'd2) r = 8'h56;
    else if (q == 8'd4) r = 8'h47;
    else if (q[0] || q < 8'd6) r = 8'd0;
    else if (nib < 4'd10) r = 8'h30 + {4'd0, nib};
    else r = 8'h37 + {4'd0, nib};
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/usb_hid_control_endpoint.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  signals                            contents
// s_axis    in   s_tvalid s_tready s_tdata s_tuser  one bus event, tlast = reply_last
// m_axis    out  m_tvalid m_tready m_tdata m_tlast  one result, tlast = byte_last
// cfg       in   cfg_we cfg_index cfg_data          vendor, product, chip id
//
// an item is taken and decoded in the cycle after; each result then
// takes a fetch from the descriptor rom or reply store and a send, which
// may be held by output stalls; an item gives 1 to PACKET_BYTES results.
// the next item is taken only after the last result of the current one.
// rst is synchronous; there is no clearing pass, the reply store reads zero
// until written through per-entry valid bits.
module usb_hid_control_endpoint import usbhid_pkg::*; #(
  parameter int PACKET_BYTES = PKT_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // request_type, request_code, value_word, index_word, length_word,
  // received_len, toggle_ok, reply_byte
  input  wire logic [79:0] s_tdata,
  // mode
  input  wire logic [2:0]  s_tuser,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // ep0_handshake, tx_byte, tx_valid, tx_count, data_toggle, device_address,
  // config_value, rx_ready, ep1_out_nak, ep1_in_armed, zero pad
  output logic [39:0]      m_tdata,
  output logic             m_tlast
);

  usbhid_cmd_t    cmd;
  usbhid_status_t status;

  usbhid_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .status(status), .cmd(cmd)
  );

  usbhid_dp #(.PACKET_BYTES(PACKET_BYTES)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_data(s_tdata), .in_mode(s_tuser), .in_last(s_tlast), .cmd(cmd),
    .status(status), .out_data(m_tdata), .out_last(m_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/usbhid_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module usbhid_ctrl import usbhid_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  wire logic           m_tready,
  input  wire usbhid_status_t status,
  output usbhid_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_SEND  = 4'b1000
  } state_t;

  state_t state, state_next;

  // sequencing
  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.latch = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          cmd.send = 1'b1;
          state_next = status.last ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_EXEC))
    else $error("accepted item not executed");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while a result is shown");
  a_send_next: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !status.last) |=> (state == ST_FETCH))
    else $error("missing fetch after a non-last result");
  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> !cmd.exec)
    else $error("item executed twice");

endmodule

`default_nettype wire

// ----- rtl/usbhid_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module usbhid_dp import usbhid_pkg::*; #(
  parameter int PACKET_BYTES = PKT_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [79:0] in_data,
  input  wire logic [2:0]  in_mode,
  input  wire logic        in_last,
  input  wire usbhid_cmd_t cmd,
  output usbhid_status_t   status,
  output logic [39:0]      out_data,
  output logic             out_last
);

  localparam logic [6:0] PB = 7'(PACKET_BYTES);

  // latched item
  logic [2:0]  l_mode;
  logic [7:0]  l_type, l_code, l_index, l_rbyte;
  logic [15:0] l_value, l_length;
  logic [6:0]  l_rlen;
  logic        l_tok, l_rlast;

  // config registers
  logic [15:0] vid, pid;
  logic [31:0] chip;

  // device state
  logic [7:0]  saved_code, saved_type, sptr, cfgv;
  logic [15:0] br;
  logic        sreply, rw, tog, onak, iarm;
  logic [6:0]  pend, act;
  logic [5:0]  widx;

  // emission state
  logic [1:0]  hs_q, esrc;
  logic [6:0]  n_q, k;
  logic        pkt_q;
  logic [7:0]  eptr, fixb;

  logic [7:0]  saved_code_next, saved_type_next, sptr_next, cfgv_next;
  logic [15:0] br_next;
  logic        sreply_next, rw_next, tog_next, onak_next, iarm_next;
  logic [6:0]  pend_next, act_next;
  logic [5:0]  widx_next;
  logic [1:0]  hs_next, esrc_next;
  logic [6:0]  n_next;
  logic        pkt_next;
  logic [7:0]  eptr_next, fixb_next;

  // reply store
  logic [7:0]  mem [0:63];
  logic [63:0] mem_valid;
  logic [7:0]  mem_q, rom_q, addr, tx_byte;
  logic        memv_q;

  logic        stall, do_chunk, ch_reply, std_req;
  logic [7:0]  ch_ptr, rs;
  logic [15:0] ch_br, rl;
  logic [6:0]  ch_n;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      l_mode   <= in_mode;
      l_type   <= in_data[7:0];
      l_code   <= in_data[15:8];
      l_value  <= in_data[31:16];
      l_index  <= in_data[39:32];
      l_length <= in_data[63:48];
      l_rlen   <= in_data[70:64];
      l_tok    <= in_data[71];
      l_rbyte  <= in_data[79:72];
      l_rlast  <= in_last;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vid <= '0;
      pid <= '0;
      chip <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VENDOR:  vid <= cfg_data[15:0];
        CFG_PRODUCT: pid <= cfg_data[15:0];
        CFG_CHIP_ID: chip <= cfg_data;
        default: ;
      endcase
    end
  end

  // item decode
  always_comb begin
    saved_code_next = saved_code;
    saved_type_next = saved_type;
    sptr_next = sptr;
    cfgv_next = cfgv;
    br_next = br;
    sreply_next = sreply;
    rw_next = rw;
    tog_next = tog;
    onak_next = onak;
    iarm_next = iarm;
    pend_next = pend;
    act_next = act;
    widx_next = widx;
    hs_next = HS_KEEP;
    esrc_next = esrc;
    n_next = '0;
    pkt_next = 1'b0;
    eptr_next = eptr;
    fixb_next = fixb;
    stall = 1'b0;
    do_chunk = 1'b0;
    ch_reply = sreply;
    ch_ptr = sptr;
    ch_br = br;
    rs = '0;
    rl = '0;
    std_req = (saved_type[6:5] == RT_STANDARD);
    case (l_mode)
      MODE_SETUP: begin
        tog_next = 1'b1;
        if (l_rlen != 7'd8) begin
          stall = 1'b1;
        end else begin
          saved_code_next = l_code;
          saved_type_next = l_type;
          br_next = l_length;
          if (l_type[6:5] == RT_CLASS) begin
            case (l_code)
              CLS_GET_REPORT: begin
                do_chunk = 1'b1;
                ch_reply = 1'b1;
                ch_ptr = '0;
                ch_br = (l_length > 16'd64) ? 16'd64 : l_length;
              end
              CLS_SET_REPORT, CLS_SET_IDLE, CLS_SET_PROTOCOL: ;
              CLS_GET_IDLE: begin
                esrc_next = SRC_FIXED; fixb_next = 8'd0; n_next = 7'd1;
              end
              CLS_GET_PROTOCOL: begin
                esrc_next = SRC_FIXED; fixb_next = 8'd1; n_next = 7'd1;
              end
              default: stall = 1'b1;
            endcase
          end else if (l_type[6:5] != RT_STANDARD) begin
            stall = 1'b1;
          end else begin
            case (l_code)
              REQ_GET_DESC: begin
                do_chunk = 1'b1;
                case (l_value[15:8])
                  DT_DEVICE: begin rs = 8'd0; rl = 16'd18; end
                  DT_CONFIG: begin rs = 8'd18; rl = 16'd41; end
                  DT_HID:    begin rs = 8'd36; rl = 16'd9; end
                  DT_REPORT: begin rs = 8'd59; rl = 16'd27; end
                  DT_STRING: begin
                    case (l_value[7:0])
                      8'd0: begin rs = 8'd86; rl = 16'd4; end
                      8'd1: begin rs = 8'd90; rl = 16'd22; end
                      8'd2: begin rs = 8'd112; rl = 16'd18; end
                      8'd3: begin rs = SERIAL_AT; rl = 16'd22; end
                      default: begin stall = 1'b1; do_chunk = 1'b0; end
                    endcase
                  end
                  default: begin stall = 1'b1; do_chunk = 1'b0; end
                endcase
                ch_reply = 1'b0;
                ch_ptr = rs;
                ch_br = (l_length > rl) ? rl : l_length;
              end
              REQ_SET_ADDRESS: pend_next = l_value[6:0];
              REQ_GET_CONFIG: begin
                esrc_next = SRC_FIXED; fixb_next = cfgv;
                n_next = (l_length != 16'd0) ? 7'd1 : 7'd0;
              end
              REQ_SET_CONFIG: cfgv_next = l_value[7:0];
              REQ_GET_IFACE: begin
                esrc_next = SRC_FIXED; fixb_next = 8'd0;
                n_next = (l_length != 16'd0) ? 7'd1 : 7'd0;
              end
              REQ_SET_IFACE: ;
              REQ_GET_STATUS: begin
                esrc_next = SRC_FIXED; fixb_next = 8'd0;
                n_next = (l_length >= 16'd2) ? 7'd2 : l_length[6:0];
              end
              REQ_CLEAR_FEATURE: begin
                if (l_type[4:0] != RCPT_ENDPOINT) stall = 1'b1;
                else if (l_index == EP1_IN_ADDR) iarm_next = 1'b0;
                else if (l_index == EP1_OUT_ADDR) onak_next = 1'b0;
                else stall = 1'b1;
              end
              default: stall = 1'b1;
            endcase
          end
        end
      end
      MODE_IN0: begin
        if (std_req && saved_code == REQ_GET_DESC) begin
          do_chunk = 1'b1;
          tog_next = ~tog;
          pkt_next = 1'b1;
        end else begin
          if (std_req && saved_code == REQ_SET_ADDRESS) act_next = pend;
          tog_next = 1'b0;
          hs_next = HS_NAK;
        end
      end
      MODE_OUT0: begin
        if (saved_type[6:5] == RT_CLASS && saved_code == CLS_SET_REPORT) begin
          if (l_tok) begin
            rw_next = 1'b1;
            hs_next = HS_ACK;
          end
        end else begin
          tog_next = 1'b0;
          hs_next = HS_NAK;
        end
      end
      MODE_OUT1: begin
        if (l_tok) begin
          rw_next = 1'b1;
          onak_next = 1'b1;
        end
      end
      MODE_IN1: iarm_next = 1'b0;
      MODE_BUS_RST: begin
        tog_next = 1'b0;
        hs_next = HS_NAK;
        iarm_next = 1'b0;
        onak_next = 1'b0;
        act_next = '0;
        cfgv_next = '0;
        rw_next = 1'b0;
      end
      MODE_REPLY: begin
        widx_next = widx + 6'd1;
        if (l_rlast) begin
          widx_next = '0;
          rw_next = 1'b0;
          iarm_next = 1'b1;
          onak_next = 1'b0;
        end
      end
      default: ;
    endcase
    // chunk of up to one packet
    ch_n = (ch_br > {9'd0, PB}) ? PB : ch_br[6:0];
    if (do_chunk) begin
      n_next = ch_n;
      br_next = ch_br - {9'd0, ch_n};
      sptr_next = ch_ptr + {1'b0, ch_n};
      sreply_next = ch_reply;
      esrc_next = ch_reply ? SRC_REPLY : SRC_ROM;
      eptr_next = ch_ptr;
    end
    if (l_mode == MODE_SETUP) begin
      if (stall) begin
        saved_code_next = REQ_INVALID;
        hs_next = HS_STALL;
        n_next = '0;
      end else begin
        hs_next = HS_ACK;
        pkt_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_code <= '0;
      saved_type <= '0;
      sptr <= '0;
      cfgv <= '0;
      br <= '0;
      sreply <= 1'b0;
      rw <= 1'b0;
      tog <= 1'b0;
      onak <= 1'b0;
      iarm <= 1'b0;
      pend <= '0;
      act <= '0;
      widx <= '0;
      hs_q <= HS_KEEP;
      esrc <= SRC_ROM;
      n_q <= '0;
      pkt_q <= 1'b0;
      eptr <= '0;
      fixb <= '0;
      k <= '0;
    end else begin
      if (cmd.exec) begin
        saved_code <= saved_code_next;
        saved_type <= saved_type_next;
        sptr <= sptr_next;
        cfgv <= cfgv_next;
        br <= br_next;
        sreply <= sreply_next;
        rw <= rw_next;
        tog <= tog_next;
        onak <= onak_next;
        iarm <= iarm_next;
        pend <= pend_next;
        act <= act_next;
        widx <= widx_next;
        hs_q <= hs_next;
        esrc <= esrc_next;
        n_q <= n_next;
        pkt_q <= pkt_next;
        eptr <= eptr_next;
        fixb <= fixb_next;
        k <= '0;
      end else if (cmd.send) begin
        k <= k + 7'd1;
      end
    end
  end

  // reply store, with valid bits standing for the zero reset
  always_ff @(posedge clk) begin
    if (cmd.exec && l_mode == MODE_REPLY) mem[widx] <= l_rbyte;
  end

  always_ff @(posedge clk) begin
    if (rst) mem_valid <= '0;
    else if (cmd.exec && l_mode == MODE_REPLY) mem_valid[widx] <= 1'b1;
  end

  // byte fetch
  assign addr = eptr + {1'b0, k};

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      mem_q <= mem[addr[5:0]];
      memv_q <= mem_valid[addr[5:0]];
      rom_q <= image_byte(addr, vid, pid, chip, {1'b0, PB});
    end
  end

  always_comb begin
    if (n_q == 7'd0) tx_byte = 8'd0;
    else if (esrc == SRC_FIXED) tx_byte = fixb;
    else if (esrc == SRC_REPLY) tx_byte = memv_q ? mem_q : 8'd0;
    else tx_byte = rom_q;
  end

  assign status.last = (n_q == 7'd0) || (k == n_q - 7'd1);
  assign out_last = status.last;

  assign out_data = {3'd0, iarm, onak, rw, cfgv, act, tog,
                     (pkt_q ? n_q : 7'd0), (n_q != 7'd0), tx_byte, hs_q};

endmodule

`default_nettype wire
